### hw/rtl/lspe_pkg.sv
`default_nettype none

package lspe_pkg;

	// Strip geometry.
	localparam int NUM_PIXELS = 64;
	localparam int PIX_AW     = (NUM_PIXELS > 1) ? $clog2(NUM_PIXELS) : 1;
	localparam int PIX_CW     = $clog2(NUM_PIXELS + 1);
	localparam int PIXEL_BITS = 24;
	localparam int BIT_CW     = 5;

	// Item modes.
	localparam logic [1:0] MODE_SET_ONE = 2'd0;
	localparam logic [1:0] MODE_SET_ALL = 2'd1;
	localparam logic [1:0] MODE_START   = 2'd2;
	localparam logic [1:0] MODE_TICK    = 2'd3;

	// Configuration register indexes.
	localparam logic [1:0] REG_CODE_ZERO     = 2'd0;
	localparam logic [1:0] REG_CODE_ONE      = 2'd1;
	localparam logic [1:0] REG_RESET_PERIODS = 2'd2;

	// Register reset values.
	localparam logic [7:0] CODE_ZERO_RST     = 8'd30;
	localparam logic [7:0] CODE_ONE_RST      = 8'd60;
	localparam logic [7:0] RESET_PERIODS_RST = 8'd48;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic write_one;
		logic fill_load;
		logic fill_write;
		logic start_frame;
		logic emit;
	} lspe_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic fill_last;
		logic out_free;
	} lspe_sts_t;

endpackage

`default_nettype wire

### hw/rtl/lspe_ram.sv
`default_nettype none

module lspe_ram #(
	parameter int WIDTH  = 24,
	parameter int DEPTH  = 64,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

### hw/rtl/lspe_ctrl.sv
`default_nettype none

module lspe_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               item_valid,
	output logic                    item_ready,
	input  wire logic [1:0]         mode,
	input  wire lspe_pkg::lspe_sts_t sts,
	output lspe_pkg::lspe_cmd_t     cmd
);
	import lspe_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_FILL = 2'd1;
	localparam logic [1:0] ST_READ = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign item_ready = (state_q == ST_IDLE);

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					case (mode)
						MODE_SET_ONE: cmd.write_one = 1'b1;
						MODE_SET_ALL: begin
							cmd.fill_load = 1'b1;
							state_d       = ST_FILL;
						end
						MODE_START: cmd.start_frame = 1'b1;
						MODE_TICK: state_d = ST_READ;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_FILL: begin
				cmd.fill_write = 1'b1;
				if (sts.fill_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_READ: state_d = ST_EMIT;
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

### hw/rtl/lspe_dp.sv
`default_nettype none

module lspe_dp (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire lspe_pkg::lspe_cmd_t cmd,
	output lspe_pkg::lspe_sts_t     sts,
	input  wire logic [5:0]         pixel_index,
	input  wire logic [7:0]         red,
	input  wire logic [7:0]         green,
	input  wire logic [7:0]         blue,
	input  wire logic               cfg_valid,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [7:0]         cfg_data,
	output logic                    result_valid,
	input  wire logic               result_ready,
	output logic [7:0]              compare_value,
	output logic                    frame_active,
	output logic                    frame_end
);
	import lspe_pkg::*;

	logic [7:0]            code_zero_q;
	logic [7:0]            code_one_q;
	logic [7:0]            reset_periods_q;
	logic [PIXEL_BITS-1:0] colour_q;
	logic [PIX_AW-1:0]     fill_q;
	logic [NUM_PIXELS-1:0] written_q;
	logic                  sending_q;
	logic [PIX_CW-1:0]     pixel_cnt_q;
	logic [BIT_CW-1:0]     bit_cnt_q;
	logic [7:0]            tail_cnt_q;
	logic                  out_valid_q;
	logic [7:0]            cmp_q;
	logic                  active_q;
	logic                  end_q;

	logic                  idx_ok;
	logic                  ram_we;
	logic [PIX_AW-1:0]     ram_waddr;
	logic [PIXEL_BITS-1:0] ram_wdata;
	logic [PIXEL_BITS-1:0] pix_word;
	logic [PIX_AW-1:0]     rd_idx;

	logic                  sending_d;
	logic [PIX_CW-1:0]     pixel_cnt_d;
	logic [BIT_CW-1:0]     bit_cnt_d;
	logic [7:0]            tail_cnt_d;
	logic [7:0]            cmp_d;
	logic                  active_d;
	logic                  end_d;
	logic                  data_bit;

	assign idx_ok = (32'(pixel_index) < NUM_PIXELS);
	assign rd_idx = pixel_cnt_q[PIX_AW-1:0];

	// Write port: a single pixel write or one step of the set-all sweep.
	always_comb begin
		if (cmd.fill_write) begin
			ram_we    = 1'b1;
			ram_waddr = fill_q;
			ram_wdata = colour_q;
		end else begin
			ram_we    = cmd.write_one && idx_ok;
			ram_waddr = PIX_AW'(pixel_index);
			ram_wdata = {green, red, blue};
		end
	end

	lspe_ram #(
		.WIDTH(PIXEL_BITS),
		.DEPTH(NUM_PIXELS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(rd_idx),
		.rdata(pix_word)
	);

	assign sts.fill_last = (32'(fill_q) == NUM_PIXELS - 1);
	assign sts.out_free  = !out_valid_q || result_ready;

	// Result of one tick and the frame counters that follow from it.
	always_comb begin
		sending_d   = sending_q;
		pixel_cnt_d = pixel_cnt_q;
		bit_cnt_d   = bit_cnt_q;
		tail_cnt_d  = tail_cnt_q;
		cmp_d       = 8'd0;
		active_d    = 1'b0;
		end_d       = 1'b0;
		data_bit    = pix_word[BIT_CW'(PIXEL_BITS - 1) - bit_cnt_q];
		if (sending_q) begin
			active_d = 1'b1;
			if (pixel_cnt_q < PIX_CW'(NUM_PIXELS)) begin
				if (written_q[rd_idx]) begin
					cmp_d = data_bit ? code_one_q : code_zero_q;
				end
				if (bit_cnt_q == BIT_CW'(PIXEL_BITS - 1)) begin
					bit_cnt_d   = '0;
					pixel_cnt_d = pixel_cnt_q + 1'b1;
					if (pixel_cnt_q == PIX_CW'(NUM_PIXELS - 1) && reset_periods_q == 8'd0) begin
						end_d     = 1'b1;
						sending_d = 1'b0;
					end
				end else begin
					bit_cnt_d = bit_cnt_q + 1'b1;
				end
			end else begin
				tail_cnt_d = tail_cnt_q + 8'd1;
				if (tail_cnt_d >= reset_periods_q || tail_cnt_d == 8'd0) begin
					end_d     = 1'b1;
					sending_d = 1'b0;
				end
			end
		end
	end

	// Configuration registers, taken on every transfer of the write channel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_zero_q     <= CODE_ZERO_RST;
			code_one_q      <= CODE_ONE_RST;
			reset_periods_q <= RESET_PERIODS_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_CODE_ZERO:     code_zero_q     <= cfg_data;
				REG_CODE_ONE:      code_one_q      <= cfg_data;
				REG_RESET_PERIODS: reset_periods_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sweep address and colour for set-all.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (cmd.fill_load) begin
			fill_q <= '0;
		end else if (cmd.fill_write) begin
			fill_q <= fill_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fill_load) begin
			colour_q <= {green, red, blue};
		end
	end

	// Written flags, one per pixel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
		end else if (ram_we) begin
			written_q[ram_waddr] <= 1'b1;
		end
	end

	// Frame state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sending_q   <= 1'b0;
			pixel_cnt_q <= '0;
			bit_cnt_q   <= '0;
			tail_cnt_q  <= '0;
		end else if (cmd.start_frame && !sending_q) begin
			sending_q   <= 1'b1;
			pixel_cnt_q <= '0;
			bit_cnt_q   <= '0;
			tail_cnt_q  <= '0;
		end else if (cmd.emit) begin
			sending_q   <= sending_d;
			pixel_cnt_q <= pixel_cnt_d;
			bit_cnt_q   <= bit_cnt_d;
			tail_cnt_q  <= tail_cnt_d;
		end
	end

	// Output register: holds a result until its transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			cmp_q    <= cmp_d;
			active_q <= active_d;
			end_q    <= end_d;
		end
	end

	assign result_valid  = out_valid_q;
	assign compare_value = cmp_q;
	assign frame_active  = active_q;
	assign frame_end     = end_q;

endmodule

`default_nettype wire

### hw/rtl/led_strip_pulse_encoder.sv
// LED strip pulse encoder. Pixels are kept in a 64 x 24-bit memory (green,
// red, blue) and sent as one PWM compare value per tick, most significant bit
// first, followed by reset_periods zero values, the last of them flagged as
// frame_end. A set-pixel or start item is done in its accept step. A tick
// passes through accept, memory read and result load, and waits at the result
// load while the previous result has not yet been taken; the registered read
// of the pixel memory sets the memory read step. A set-all item sweeps the
// memory, one pixel a cycle through the single write port. Configuration
// writes are taken in any cycle.
`default_nettype none

module led_strip_pulse_encoder (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       item_valid,
	output logic            item_ready,
	input  wire logic [1:0] mode,
	input  wire logic [5:0] pixel_index,
	input  wire logic [7:0] red,
	input  wire logic [7:0] green,
	input  wire logic [7:0] blue,
	output logic            result_valid,
	input  wire logic       result_ready,
	output logic [7:0]      compare_value,
	output logic            frame_active,
	output logic            frame_end,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [1:0] cfg_index,
	input  wire logic [7:0] cfg_data
);
	import lspe_pkg::*;

	lspe_cmd_t cmd;
	lspe_sts_t sts;

	assign cfg_ready = 1'b1;

	lspe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.mode      (mode),
		.sts       (sts),
		.cmd       (cmd)
	);

	lspe_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.pixel_index  (pixel_index),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.compare_value(compare_value),
		.frame_active (frame_active),
		.frame_end    (frame_end)
	);

endmodule

`default_nettype wire

### hw/rtl/lspe_chk.sv
`default_nettype none

module lspe_chk (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       item_valid,
	input wire logic       item_ready,
	input wire logic [1:0] mode,
	input wire logic       result_valid,
	input wire logic       result_ready,
	input wire logic [7:0] compare_value,
	input wire logic       frame_active,
	input wire logic       frame_end
);
	import lspe_pkg::*;

	// The end of a frame always belongs to a frame.
	a_end_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && frame_end |-> frame_active)
		else $error("frame_end shown outside a frame");

	// A tick outside a frame gives a zero value.
	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !frame_active |-> compare_value == 8'd0)
		else $error("non-zero compare value outside a frame");

	// A set-all transfer starts a sweep that blocks the next item.
	a_fill_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && mode == MODE_SET_ALL |=> !item_ready)
		else $error("item taken during the set-all sweep");

	// A tick transfer blocks the next item while the memory is read.
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && mode == MODE_TICK |=> !item_ready)
		else $error("item taken during a memory read");

	// A stalled result holds.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(compare_value))
		else $error("stalled result changed");

endmodule

bind led_strip_pulse_encoder lspe_chk u_lspe_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_ready   (item_ready),
	.mode         (mode),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.compare_value(compare_value),
	.frame_active (frame_active),
	.frame_end    (frame_end)
);

`default_nettype wire

### tb/led_strip_pulse_encoder_test.sv
`timescale 1ns / 1ps

module led_strip_pulse_encoder_test;
	import lspe_pkg::*;

	localparam int SETTLE_CYCLES = 100;
	localparam int LONG_HOLD     = 400;
	localparam int STALL_LIMIT   = 5000;

	typedef struct packed {
		logic [1:0] mode;
		logic [5:0] idx;
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} led_item_t;

	typedef struct packed {
		logic [7:0] cmp;
		logic       active;
		logic       fin;
	} pulse_t;

	// Ports of the block; the inputs are at known values from time zero.
	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       item_valid = 1'b0;
	logic       item_ready;
	logic [1:0] mode = MODE_TICK;
	logic [5:0] pixel_index = '0;
	logic [7:0] red = '0;
	logic [7:0] green = '0;
	logic [7:0] blue = '0;
	logic       result_valid;
	logic       result_ready = 1'b0;
	logic [7:0] compare_value;
	logic       frame_active;
	logic       frame_end;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [1:0] cfg_index = REG_CODE_ZERO;
	logic [7:0] cfg_data = '0;

	led_strip_pulse_encoder uut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.mode(mode),
		.pixel_index(pixel_index),
		.red(red),
		.green(green),
		.blue(blue),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.compare_value(compare_value),
		.frame_active(frame_active),
		.frame_end(frame_end),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Encoder state as the testbench sees it.
	logic [23:0] pixel_mem [NUM_PIXELS];
	logic        pixel_set [NUM_PIXELS];
	logic        sending = 1'b0;
	int          px_pos = 0;
	int          bit_pos = 0;
	logic [7:0]  tail_count = '0;
	logic [7:0]  cfg_zero = CODE_ZERO_RST;
	logic [7:0]  cfg_one = CODE_ONE_RST;
	logic [7:0]  cfg_tail = RESET_PERIODS_RST;
	int          frames_done = 0;
	bit          seen_empty_tail = 1'b0;

	led_item_t   pending_items [$];
	pulse_t      pulses_due [$];
	led_item_t   offered;
	int          send_gap = 0;
	int          hold_left = 0;
	bit          long_hold_done = 1'b0;
	int          results_taken = 0;
	int          fault_count = 0;
	int          quiet_cycles = 0;
	bit          calm = 1'b0;
	pulse_t      want;

	initial begin
		for (int i = 0; i < NUM_PIXELS; i++) begin
			pixel_mem[i] = '0;
			pixel_set[i] = 1'b0;
		end
	end

	task automatic log_fault(input string msg);
		fault_count++;
		if (fault_count <= 10)
			$display("%s", msg);
	endtask

	// Applies one accepted item to the encoder state and queues the pulse that a tick yields.
	task automatic encode_item(input led_item_t it);
		pulse_t p;
		int     bc;
		p = '0;
		case (it.mode)
			MODE_SET_ONE: begin
				if (int'(it.idx) < NUM_PIXELS) begin
					pixel_mem[it.idx] = {it.g, it.r, it.b};
					pixel_set[it.idx] = 1'b1;
				end
			end
			MODE_SET_ALL: begin
				for (int i = 0; i < NUM_PIXELS; i++) begin
					pixel_mem[i] = {it.g, it.r, it.b};
					pixel_set[i] = 1'b1;
				end
			end
			MODE_START: begin
				if (!sending) begin
					sending = 1'b1;
					px_pos = 0;
					bit_pos = 0;
					tail_count = '0;
				end
			end
			default: begin
				if (sending) begin
					p.active = 1'b1;
					if (px_pos < NUM_PIXELS) begin
						bc = (bit_pos < PIXEL_BITS) ? bit_pos : PIXEL_BITS - 1;
						if (pixel_set[px_pos])
							p.cmp = pixel_mem[px_pos][PIXEL_BITS - 1 - bc] ? cfg_one : cfg_zero;
						if (bc >= PIXEL_BITS - 1) begin
							bit_pos = 0;
							px_pos++;
							if (px_pos >= NUM_PIXELS && cfg_tail == 0) begin
								p.fin = 1'b1;
								sending = 1'b0;
								seen_empty_tail = 1'b1;
							end
						end else begin
							bit_pos = bc + 1;
						end
					end else begin
						tail_count = tail_count + 8'd1;
						if (tail_count >= cfg_tail || tail_count == 0) begin
							p.fin = 1'b1;
							sending = 1'b0;
						end
					end
				end
				if (p.fin)
					frames_done++;
				pulses_due.push_back(p);
			end
		endcase
	endtask

	// Item driver: predicts on each transfer, then offers the next pending item.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			send_gap = 0;
		end else begin
			if (item_valid && item_ready)
				encode_item(offered);
			if (!item_valid || item_ready) begin
				if (send_gap > 0) begin
					send_gap--;
					item_valid <= 1'b0;
				end else if (pending_items.size() != 0) begin
					offered = pending_items.pop_front();
					item_valid <= 1'b1;
					mode <= offered.mode;
					pixel_index <= offered.idx;
					red <= offered.r;
					green <= offered.g;
					blue <= offered.b;
					if (!calm && $urandom_range(0, 9) == 0)
						send_gap = $urandom_range(1, 11);
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: checks each transfer against the oldest due pulse and paces ready.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
			hold_left = 0;
		end else begin
			if (result_valid && result_ready) begin
				results_taken++;
				if (pulses_due.size() == 0) begin
					log_fault($sformatf("unexpected result: cmp=%0d active=%0b end=%0b",
						compare_value, frame_active, frame_end));
				end else begin
					want = pulses_due.pop_front();
					if (compare_value !== want.cmp || frame_active !== want.active ||
							frame_end !== want.fin)
						log_fault($sformatf(
							"result %0d: expected cmp=%0d active=%0b end=%0b, got cmp=%0d active=%0b end=%0b",
							results_taken, want.cmp, want.active, want.fin,
							compare_value, frame_active, frame_end));
				end
			end
			// Hold off once for a long stretch so that items pile up in front of the block.
			if (!long_hold_done && results_taken >= 300 && pending_items.size() >= 10) begin
				hold_left = LONG_HOLD;
				long_hold_done = 1'b1;
			end else if (hold_left == 0 && !calm && $urandom_range(0, 11) == 0) begin
				hold_left = $urandom_range(1, 11);
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ready <= 1'b0;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	// Watchdog on cycles without any transfer.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && item_ready) || (result_valid && result_ready) ||
					(cfg_valid && cfg_ready)) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
				if (quiet_cycles >= STALL_LIMIT) begin
					$display("Test completed with failures");
					$finish;
				end
			end
		end
	end

	task automatic write_reg(input logic [1:0] which, input logic [7:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= which;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		case (which)
			REG_CODE_ZERO: cfg_zero = val;
			REG_CODE_ONE:  cfg_one = val;
			default:       cfg_tail = val;
		endcase
	endtask

	// Waits until every item is taken and every pulse has come, then lets a sweep finish.
	task automatic settle();
		do
			@(posedge clk);
		while (pending_items.size() != 0 || item_valid || pulses_due.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic led_item_t make_item(input logic [1:0] m, input int idx,
			input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
		led_item_t it;
		it.mode = m;
		it.idx = idx[5:0];
		it.r = r;
		it.g = g;
		it.b = b;
		return it;
	endfunction

	// Mostly ticks; a fill only once never-written pixels have had time to be sent.
	function automatic led_item_t random_item(input bit allow_fill);
		led_item_t it;
		int        w;
		it = led_item_t'($urandom);
		w = $urandom_range(0, 99);
		if (w < 75)
			it.mode = MODE_TICK;
		else if (w < 83)
			it.mode = MODE_START;
		else if (w < 97 || !allow_fill)
			it.mode = MODE_SET_ONE;
		else
			it.mode = MODE_SET_ALL;
		if ($urandom_range(0, 7) == 0) begin
			it.r = {8{it.b[0]}};
			it.g = {8{it.b[1]}};
			it.b = {8{it.b[2]}};
		end
		return it;
	endfunction

	function automatic logic [7:0] pick_code();
		case ($urandom_range(0, 3))
			0:       return 8'd0;
			1:       return 8'd255;
			default: return 8'($urandom);
		endcase
	endfunction

	initial begin
		int         phase_len;
		int         n_random;
		bit         seen_cut_tail;
		logic [7:0] tail_len;

		n_random = 0;
		seen_cut_tail = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed opening under reset register values: idle tick, extreme colours,
		// a start during a frame and a rewrite of a pixel that is still to be sent.
		pending_items.push_back(make_item(MODE_TICK, 0, 8'h00, 8'h00, 8'h00));
		pending_items.push_back(make_item(MODE_SET_ONE, 0, 8'hff, 8'hff, 8'hff));
		pending_items.push_back(make_item(MODE_SET_ONE, 63, 8'h00, 8'h00, 8'h00));
		pending_items.push_back(make_item(MODE_SET_ONE, 1, 8'h5a, 8'ha5, 8'h3c));
		pending_items.push_back(make_item(MODE_START, 0, 8'h00, 8'h00, 8'h00));
		repeat (4) pending_items.push_back(make_item(MODE_TICK, 0, 8'h00, 8'h00, 8'h00));
		pending_items.push_back(make_item(MODE_START, 0, 8'h00, 8'h00, 8'h00));
		repeat (4) pending_items.push_back(make_item(MODE_TICK, 63, 8'hff, 8'hff, 8'hff));
		pending_items.push_back(make_item(MODE_SET_ONE, 0, 8'h00, 8'h00, 8'h00));
		repeat (6) pending_items.push_back(make_item(MODE_TICK, 0, 8'h00, 8'h00, 8'h00));
		settle();

		// Random phases, with fresh register settings between them, until about
		// 900 random items have been sent.
		while (n_random < 900) begin
			if (sending && px_pos >= NUM_PIXELS && tail_count >= 1 &&
					(!seen_cut_tail || $urandom_range(0, 3) == 0)) begin
				tail_len = 8'($urandom_range(0, tail_count));
				seen_cut_tail = 1'b1;
			end else if (sending && px_pos >= NUM_PIXELS - 4 && px_pos < NUM_PIXELS &&
					!seen_empty_tail) begin
				tail_len = 8'd0;
			end else begin
				case ($urandom_range(0, 7))
					0:       tail_len = 8'd0;
					1:       tail_len = 8'd255;
					2:       tail_len = 8'($urandom);
					default: tail_len = 8'($urandom_range(1, 16));
				endcase
			end
			write_reg(REG_CODE_ZERO, pick_code());
			write_reg(REG_CODE_ONE, pick_code());
			write_reg(REG_RESET_PERIODS, tail_len);

			calm = (n_random >= 750);
			phase_len = $urandom_range(20, 120);
			for (int i = 0; i < phase_len; i++) begin
				pending_items.push_back(random_item(frames_done >= 1 || n_random >= 450));
				n_random++;
			end
			settle();
		end

		repeat (20) @(posedge clk);
		if (pulses_due.size() != 0)
			log_fault($sformatf("%0d results never arrived", pulses_due.size()));
		if (fault_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
